/* design/triangle_incenter_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the triangle incenter unit
// Clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_INCENTER_UNIT_ASSERT_SVH
`define TRIANGLE_INCENTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TIC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("triangle_incenter_unit: same-cycle check failed");

// next-cycle implication
`define TIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("triangle_incenter_unit: next-cycle check failed");

`endif

/* design/tic_pkg.sv */
// ---------------------------------------------------------------------------
// tic_pkg
// Widths and types shared by the incenter pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package tic_pkg;
    localparam int CW     = 24;          // coordinate width
    localparam int SQ_W   = 2 * CW;      // one squared difference
    localparam int V_W    = SQ_W + 1;    // dx^2 + dy^2
    localparam int RT_W   = 25;          // floor(sqrt(V)) < 2^24.5
    localparam int SQ_N   = RT_W;        // one root bit per stage
    localparam int REM_W  = RT_W * 2 + 1;// root remainder / trial width
    localparam int PER_W  = RT_W + 2;    // sum of three sides
    localparam int PROD_W = RT_W + CW;   // weight * coordinate
    localparam int DIV_N  = CW;          // quotient bits
    localparam int NUM_W  = PER_W + DIV_N; // weighted sum (fits 51 bits)

    localparam logic [CW-1:0] BIAS = {1'b1, {(CW-1){1'b0}}};

    typedef logic [CW-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
    } t_tri;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        logic   deg;
    } t_side;
endpackage
`default_nettype wire

/* design/tic_isqrt.sv */
// ---------------------------------------------------------------------------
// tic_isqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ---------------------------------------------------------------------------
`default_nettype none
module tic_isqrt
    import tic_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [REM_W-1:0]  i_val,
    output logic [RT_W-1:0]  o_root
);
    logic [RT_W-1:0]  s_root [0:SQ_N];
    logic [REM_W-1:0] s_rem  [0:SQ_N];
    logic [RT_W-1:0]  r_root [0:SQ_N-1];
    logic [REM_W-1:0] r_rem  [0:SQ_N-1];

    assign s_root[0] = '0;
    assign s_rem[0]  = i_val;

    for (genvar k = 0; k < SQ_N; k++) begin : g_stage
        localparam int B = SQ_N - 1 - k;
        logic [REM_W-1:0] n_trial;
        logic [REM_W-1:0] n_rem;
        logic [RT_W-1:0]  n_root;

        // (2r + 2^B) * 2^B, r holds only bits above B
        always_comb begin
            n_trial = (REM_W'(s_root[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
            if (s_rem[k] >= n_trial) begin
                n_rem  = s_rem[k] - n_trial;
                n_root = s_root[k] | (RT_W'(1) << B);
            end else begin
                n_rem  = s_rem[k];
                n_root = s_root[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end

        assign s_root[k+1] = r_root[k];
        assign s_rem[k+1]  = r_rem[k];
    end

    assign o_root = s_root[SQ_N];
endmodule
`default_nettype wire

/* design/tic_div.sv */
// ---------------------------------------------------------------------------
// tic_div
// Pipelined restoring divider, one quotient bit per stage. Quotient must
// fit CW bits (numerator below den * 2^CW).
// ---------------------------------------------------------------------------
`default_nettype none
module tic_div
    import tic_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [PER_W-1:0]  i_den,
    output logic [CW-1:0]    o_quo,
    output logic             o_rem_nz
);
    logic [PER_W-1:0] s_rem [0:DIV_N];
    logic [DIV_N-1:0] s_low [0:DIV_N];
    logic [CW-1:0]    s_q   [0:DIV_N];
    logic [PER_W-1:0] s_den [0:DIV_N];
    logic [PER_W-1:0] r_rem [0:DIV_N-1];
    logic [DIV_N-1:0] r_low [0:DIV_N-1];
    logic [CW-1:0]    r_q   [0:DIV_N-1];
    logic [PER_W-1:0] r_den [0:DIV_N-1];

    assign s_rem[0] = i_num[NUM_W-1:DIV_N];
    assign s_low[0] = i_num[DIV_N-1:0];
    assign s_q[0]   = '0;
    assign s_den[0] = i_den;

    for (genvar k = 0; k < DIV_N; k++) begin : g_stage
        localparam int I = DIV_N - 1 - k;
        logic [PER_W:0]   n_t;
        logic [PER_W:0]   n_diff;
        logic [PER_W-1:0] n_rem;
        logic [CW-1:0]    n_q;

        always_comb begin
            n_t    = {s_rem[k], s_low[k][I]};
            n_diff = n_t - {1'b0, s_den[k]};
            if (n_t >= {1'b0, s_den[k]}) begin
                n_rem = n_diff[PER_W-1:0];
                n_q   = s_q[k] | (CW'(1) << I);
            end else begin
                n_rem = n_t[PER_W-1:0];
                n_q   = s_q[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= s_low[k];
                r_q[k]   <= n_q;
                r_den[k] <= s_den[k];
            end
        end

        assign s_rem[k+1] = r_rem[k];
        assign s_low[k+1] = r_low[k];
        assign s_q[k+1]   = r_q[k];
        assign s_den[k+1] = r_den[k];
    end

    assign o_quo    = s_q[DIV_N];
    assign o_rem_nz = (s_rem[DIV_N] != '0) && (s_low[DIV_N] == s_low[DIV_N]);
endmodule
`default_nettype wire

/* design/triangle_incenter_unit.sv */
// Pipeline: 4 front stages, 25 root stages, 3 weighting stages, 24 divider
//   stages, 1 output register from an accepted input beat to its output beat.
// Throughput: one triangle per cycle while the skid entry is empty; every
//   unit is fully pipelined.
// Reset: synchronous, active-low i_rst_n clears all valid bits; data
//   registers are not reset.
// ---------------------------------------------------------------------------
// triangle_incenter_unit
// Incenter of a 2D triangle: sides by pipelined integer square roots,
// side-weighted vertex sum divided by the perimeter, rounded toward zero.
// ---------------------------------------------------------------------------
`default_nettype none
`include "triangle_incenter_unit_assert.svh"
module triangle_incenter_unit
    import tic_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    // tdata: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x,
    //        vertex_c_y (24 bits each, from bit 0 up)
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [143:0]  s_axis_tdata,
    // tdata: center_x [23:0], center_y [47:24]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [47:0]  m_axis_tdata,
    // tuser: degenerate
    output logic         m_axis_tuser
);
    // Whole pipe moves together; the output register plus one skid entry
    // absorb the beat in flight, so ready depends only on a register.
    logic r_skid_v;
    logic w_en;
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    // ---- stage 1: capture, convert to offset binary ------------------------
    logic r1_v;
    t_tri r1_tri;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
        end
        if (w_en) begin
            r1_tri.ax <= s_axis_tdata[23:0]    ^ BIAS;
            r1_tri.ay <= s_axis_tdata[47:24]   ^ BIAS;
            r1_tri.bx <= s_axis_tdata[71:48]   ^ BIAS;
            r1_tri.by <= s_axis_tdata[95:72]   ^ BIAS;
            r1_tri.cx <= s_axis_tdata[119:96]  ^ BIAS;
            r1_tri.cy <= s_axis_tdata[143:120] ^ BIAS;
        end
    end

    // ---- stage 2: absolute differences (AB, BC, CA; x then y) --------------
    function automatic t_coord absdiff(input t_coord a, input t_coord b);
        absdiff = (a >= b) ? a - b : b - a;
    endfunction

    logic   r2_v;
    t_tri   r2_tri;
    t_coord r2_d [0:5];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_tri  <= r1_tri;
            r2_d[0] <= absdiff(r1_tri.bx, r1_tri.ax);
            r2_d[1] <= absdiff(r1_tri.by, r1_tri.ay);
            r2_d[2] <= absdiff(r1_tri.cx, r1_tri.bx);
            r2_d[3] <= absdiff(r1_tri.cy, r1_tri.by);
            r2_d[4] <= absdiff(r1_tri.ax, r1_tri.cx);
            r2_d[5] <= absdiff(r1_tri.ay, r1_tri.cy);
        end
    end

    // ---- stage 3: squares --------------------------------------------------
    logic            r3_v;
    t_tri            r3_tri;
    logic [SQ_W-1:0] r3_sq [0:5];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
        if (w_en) begin
            r3_tri <= r2_tri;
            for (int i = 0; i < 6; i++) begin
                r3_sq[i] <= r2_d[i] * r2_d[i];
            end
        end
    end

    // ---- stage 4: squared side lengths -------------------------------------
    logic           r4_v;
    t_tri           r4_tri;
    logic [V_W-1:0] r4_sum [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
        if (w_en) begin
            r4_tri <= r3_tri;
            for (int i = 0; i < 3; i++) begin
                r4_sum[i] <= {1'b0, r3_sq[2*i]} + {1'b0, r3_sq[2*i+1]};
            end
        end
    end

    // ---- root stages: AB, BC, CA -------------------------------------------
    logic [RT_W-1:0] w_len [0:2];
    for (genvar j = 0; j < 3; j++) begin : g_root
        tic_isqrt u_isqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_val  (REM_W'(r4_sum[j])),
            .o_root (w_len[j])
        );
    end

    logic r_sq_v   [0:SQ_N-1];
    t_tri r_sq_tri [0:SQ_N-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQ_N; i++) begin
                r_sq_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_sq_v[0] <= r4_v;
            for (int i = 1; i < SQ_N; i++) begin
                r_sq_v[i] <= r_sq_v[i-1];
            end
        end
        if (w_en) begin
            r_sq_tri[0] <= r4_tri;
            for (int i = 1; i < SQ_N; i++) begin
                r_sq_tri[i] <= r_sq_tri[i-1];
            end
        end
    end

    // ---- stage 5: perimeter ------------------------------------------------
    logic             r5_v;
    t_tri             r5_tri;
    logic [RT_W-1:0]  r5_len [0:2];
    logic [PER_W-1:0] r5_per;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r_sq_v[SQ_N-1];
        end
        if (w_en) begin
            r5_tri <= r_sq_tri[SQ_N-1];
            r5_len <= w_len;
            r5_per <= PER_W'(w_len[0]) + PER_W'(w_len[1]) + PER_W'(w_len[2]);
        end
    end

    // ---- stage 6: weights times coordinates --------------------------------
    // A by |BC|, B by |CA|, C by |AB|
    logic              r6_v;
    t_side             r6_side;
    logic [PER_W-1:0]  r6_per;
    logic [PROD_W-1:0] r6_px [0:2];
    logic [PROD_W-1:0] r6_py [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
        if (w_en) begin
            r6_side.ax <= r5_tri.ax;
            r6_side.ay <= r5_tri.ay;
            r6_side.deg <= (r5_per == '0);
            r6_per   <= r5_per;
            r6_px[0] <= r5_len[1] * r5_tri.ax;
            r6_px[1] <= r5_len[2] * r5_tri.bx;
            r6_px[2] <= r5_len[0] * r5_tri.cx;
            r6_py[0] <= r5_len[1] * r5_tri.ay;
            r6_py[1] <= r5_len[2] * r5_tri.by;
            r6_py[2] <= r5_len[0] * r5_tri.cy;
        end
    end

    // ---- stage 7: weighted sums --------------------------------------------
    logic             r7_v;
    t_side            r7_side;
    logic [PER_W-1:0] r7_per;
    logic [NUM_W-1:0] r7_nx;
    logic [NUM_W-1:0] r7_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= r6_v;
        end
        if (w_en) begin
            r7_side <= r6_side;
            r7_per  <= r6_per;
            r7_nx   <= NUM_W'(r6_px[0]) + NUM_W'(r6_px[1]) + NUM_W'(r6_px[2]);
            r7_ny   <= NUM_W'(r6_py[0]) + NUM_W'(r6_py[1]) + NUM_W'(r6_py[2]);
        end
    end

    // ---- divider stages ----------------------------------------------------
    // A zero perimeter gives a junk quotient; vertex A replaces it below.
    logic [CW-1:0] w_qx, w_qy;
    logic          w_rx_nz, w_ry_nz;
    tic_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r7_nx),
        .i_den    (r7_per),
        .o_quo    (w_qx),
        .o_rem_nz (w_rx_nz)
    );
    tic_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r7_ny),
        .i_den    (r7_per),
        .o_quo    (w_qy),
        .o_rem_nz (w_ry_nz)
    );

    logic  r_dv_v    [0:DIV_N-1];
    t_side r_dv_side [0:DIV_N-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_N; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_v[0] <= r7_v;
            for (int i = 1; i < DIV_N; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
        end
        if (w_en) begin
            r_dv_side[0] <= r7_side;
            for (int i = 1; i < DIV_N; i++) begin
                r_dv_side[i] <= r_dv_side[i-1];
            end
        end
    end

    // ---- rounding: toward zero in signed form ------------------------------
    // Biased quotient below BIAS is negative: a nonzero remainder bumps it up.
    // Removing the bias mod 2^CW flips the top bit.
    t_side         w_side;
    logic          w_last_v;
    logic [CW-1:0] w_qx_adj, w_qy_adj;
    logic [48:0]   w_new;    // {degenerate, center_y, center_x}
    assign w_side   = r_dv_side[DIV_N-1];
    assign w_last_v = r_dv_v[DIV_N-1];
    always_comb begin
        w_qx_adj = (w_qx < BIAS && w_rx_nz) ? w_qx + 1'b1 : w_qx;
        w_qy_adj = (w_qy < BIAS && w_ry_nz) ? w_qy + 1'b1 : w_qy;
        if (w_side.deg) begin
            w_new = {1'b1, w_side.ay ^ BIAS, w_side.ax ^ BIAS};
        end else begin
            w_new = {1'b0, w_qy_adj ^ BIAS, w_qx_adj ^ BIAS};
        end
    end

    // ---- output register and skid entry ------------------------------------
    logic        r_out_v;
    logic [48:0] r_out;
    logic [48:0] r_skid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_last_v;
            end
        end else if (w_last_v) begin
            r_skid_v <= 1'b1;   // w_en is high whenever the skid is empty
        end
        if (!r_out_v || m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : w_new;
        end else if (!r_skid_v) begin
            r_skid <= w_new;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out[47:0];
    assign m_axis_tuser  = r_out[48];

    // ---- checks ------------------------------------------------------------
    `TIC_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_out_v)
    `TIC_ASSERT_NOW(a_skid_blocks_in, r_skid_v, !s_axis_tready)
    `TIC_ASSERT_NEXT(a_stall_to_skid,
        r_out_v && !m_axis_tready && w_last_v && w_en, r_skid_v && r_out_v)
endmodule
`default_nettype wire

/* sim/triangle_incenter_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_incenter_checker
// Watches both stream channels of the incenter unit, computes the expected
// incenter of every accepted triangle and compares each output beat with it.
// ---------------------------------------------------------------------------
module triangle_incenter_checker
    import tic_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire [143:0]  i_in_data,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire [47:0]   i_out_data,
    input  wire          i_out_deg,
    output int           o_errors,
    output int           o_pending,
    output int           o_checked,
    output int           o_degen_seen
);
    typedef struct {
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic          deg;
    } t_center;

    t_center centers_q[$];

    // floor(sqrt(v)), bitwise
    function automatic logic [63:0] isqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] side(input logic [63:0] p, input logic [63:0] q,
                                         input logic [63:0] s, input logic [63:0] t);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (p >= q) ? p - q : q - p;
        dy = (s >= t) ? s - t : t - s;
        return isqrt(128'(dx) * 128'(dx) + 128'(dy) * 128'(dy));
    endfunction

    // weighted mean on offset coordinates, truncated toward zero when signed
    function automatic logic [CW-1:0] wmean(input logic [63:0] wa, input logic [63:0] ua,
                                            input logic [63:0] wb, input logic [63:0] ub,
                                            input logic [63:0] wc, input logic [63:0] uc,
                                            input logic [63:0] per);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] r;
        n = 128'(wa) * ua + 128'(wb) * ub + 128'(wc) * uc;
        q = n / per;
        r = n % per;
        if (q < (128'd1 << (CW - 1)) && r != 0)
            q = q + 1;
        return CW'(q - (128'd1 << (CW - 1)));
    endfunction

    function automatic t_center incenter(input logic [143:0] d);
        logic [63:0] u[6];
        logic [63:0] ab;
        logic [63:0] bc;
        logic [63:0] ca;
        logic [63:0] per;
        t_center     res;
        for (int i = 0; i < 6; i++)
            u[i] = 64'(d[i*CW +: CW] ^ BIAS);
        ab  = side(u[2], u[0], u[3], u[1]);
        bc  = side(u[4], u[2], u[5], u[3]);
        ca  = side(u[0], u[4], u[1], u[5]);
        per = ab + bc + ca;
        if (per == 0) begin
            res.cx  = d[CW-1:0];
            res.cy  = d[2*CW-1:CW];
            res.deg = 1'b1;
        end else begin
            res.cx  = wmean(bc, u[0], ca, u[2], ab, u[4], per);
            res.cy  = wmean(bc, u[1], ca, u[3], ab, u[5], per);
            res.deg = 1'b0;
        end
        return res;
    endfunction

    assign o_pending = centers_q.size();

    initial begin
        o_errors     = 0;
        o_checked    = 0;
        o_degen_seen = 0;
    end

    always @(posedge i_clk) begin
        t_center want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                centers_q.push_back(incenter(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (centers_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("ERROR: output beat with nothing expected: %h deg=%b",
                                 i_out_data, i_out_deg);
                end else begin
                    want = centers_q.pop_front();
                    if (want.deg) o_degen_seen++;
                    if (i_out_data[CW-1:0] !== want.cx || i_out_data[2*CW-1:CW] !== want.cy
                        || i_out_deg !== want.deg) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("ERROR: beat %0d exp x=%h y=%h deg=%b got x=%h y=%h deg=%b",
                                     o_checked, want.cx, want.cy, want.deg,
                                     i_out_data[CW-1:0], i_out_data[2*CW-1:CW], i_out_deg);
                    end
                end
            end
        end
    end
endmodule

/* sim/triangle_incenter_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_incenter_unit_tb
// Drives triangles into the incenter unit (directed corners, then random
// shapes of many scales) with random gaps and output stalls, including one
// long output hold-off; the checker predicts and compares every beat.
// ---------------------------------------------------------------------------
module triangle_incenter_unit_tb;
    import tic_pkg::*;

    localparam int N_RANDOM  = 1700;
    localparam int LATENCY   = 57;
    localparam int MAX_CYC   = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [143:0]  s_axis_tdata;   // ax, ay, bx, by, cx, cy from bit 0
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [47:0]   m_axis_tdata;   // center_x, center_y from bit 0
    logic          m_axis_tuser;   // degenerate

    int  errors;
    int  pending;
    int  checked;
    int  degen_seen;
    int  cycles;
    bit  hold_off;    // long receiver stall request
    bit  sent_all;

    logic [143:0] tri_q[$];

    triangle_incenter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    triangle_incenter_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_deg    (m_axis_tuser),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_degen_seen (degen_seen)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // random coordinate at a random scale, so small and huge shapes both occur
    function automatic logic [CW-1:0] rnd_coord(input int sh, input logic [CW-1:0] base);
        logic [CW-1:0] off;
        off = CW'($urandom) >>> sh;
        if ($urandom_range(0, 1)) off = -off;
        return (sh >= CW - 1) ? CW'($urandom) : base + off;
    endfunction

    function automatic logic [143:0] pack_tri(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                              input logic [CW-1:0] bx, input logic [CW-1:0] by,
                                              input logic [CW-1:0] cx, input logic [CW-1:0] cy);
        return {cy, cx, by, bx, ay, ax};
    endfunction

    function automatic logic [143:0] rnd_tri();
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        int            sh;
        int            k;
        logic [143:0]  t;
        ax = CW'($urandom);
        ay = CW'($urandom);
        sh = $urandom_range(0, 23);
        t  = pack_tri(ax, ay, rnd_coord(sh, ax), rnd_coord(sh, ay),
                      rnd_coord(sh, ax), rnd_coord(sh, ay));
        k  = $urandom_range(0, 19);
        // some coincident (collinear) or fully degenerate shapes, and full-range random ones
        if (k == 0) t = pack_tri(ax, ay, ax, ay, ax, ay);
        else if (k == 1) t[2*CW +: 2*CW] = t[0 +: 2*CW];
        else if (k == 2) t = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        return t;
    endfunction

    // sender
    initial begin
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        int            g;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = BIAS;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sent_all      = 1'b0;
        // directed shapes: extremes, coincident points, degenerate lines
        tri_q.push_back(pack_tri(0, 0, 0, 0, 0, 0));
        tri_q.push_back(pack_tri(mx, mx, mx, mx, mx, mx));
        tri_q.push_back(pack_tri(mn, mn, mn, mn, mn, mn));
        tri_q.push_back(pack_tri(mn, mn, mx, mn, mn, mx));
        tri_q.push_back(pack_tri(mx, mx, mn, mx, mx, mn));
        tri_q.push_back(pack_tri(mn, mn, mx, mx, mn, mx));
        tri_q.push_back(pack_tri(mn, mx, mx, mn, mx, mx));
        tri_q.push_back(pack_tri(0, 0, 24'd256, 0, 0, 24'd256));
        tri_q.push_back(pack_tri(0, 0, 24'd1, 0, 0, 24'd1));
        tri_q.push_back(pack_tri(-24'd1, -24'd1, 0, -24'd1, -24'd1, 0));
        tri_q.push_back(pack_tri(0, 0, 0, 0, 24'd5, 24'd7));
        tri_q.push_back(pack_tri(mn, mn, mx, mx, 0, 0));
        tri_q.push_back(pack_tri(mx, mn, mx, mn, mn, mx));
        tri_q.push_back(pack_tri(24'h123456, 24'hABCDEF, 24'h123456, 24'hABCDEF,
                                 24'h123456, 24'hABCDEF));
        tri_q.push_back(pack_tri(mn, 0, mx, 0, 0, mx));
        tri_q.push_back(pack_tri(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
                                 24'h000001, 24'hFFFFFE));
        for (int i = 0; i < N_RANDOM; i++)
            tri_q.push_back(rnd_tri());

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (tri_q.size() > 0) begin
            g = gap_len();
            if (g > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= tri_q.pop_front();
            // wait for this beat to be taken
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        sent_all = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off while input keeps coming
    initial begin
        int g;
        m_axis_tready = 1'b0;
        hold_off      = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (checked >= 300 && checked < 310 && !hold_off) begin
                hold_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                g = (checked > 1000 && checked < 1200) ? 0 : gap_len();
                m_axis_tready <= (g == 0);
                if (g > 1) repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    // verdict and watchdog
    initial begin
        cycles = 0;
        while (!(sent_all && pending == 0) && cycles < MAX_CYC) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= MAX_CYC) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            repeat (LATENCY + 20) @(posedge i_clk);
            $display("Covered %0d triangles, %0d of them degenerate, in %0d cycles",
                     checked, degen_seen, cycles);
            $display("with random input gaps, output stalls and one long output hold-off.");
            if (errors == 0) begin
                $display("TEST PASSED");
            end else begin
                $display("TEST FAILED");
            end
            $finish;
        end
    end
endmodule
